>>> hdl/indent_aware_token_lexer_assert.svh
// assertion macros for the lexer checker
`ifndef INDENT_AWARE_TOKEN_LEXER_ASSERT_SVH
`define INDENT_AWARE_TOKEN_LEXER_ASSERT_SVH

// same-cycle implication
`define IATL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define IATL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/iatl_pkg.sv
`timescale 1ns / 1ps

package iatl_pkg;

  // token kinds
  localparam logic [5:0] K_INDENT   = 6'd0;
  localparam logic [5:0] K_DEDENT   = 6'd1;
  localparam logic [5:0] K_EOL      = 6'd2;
  localparam logic [5:0] K_BOOL     = 6'd3;
  localparam logic [5:0] K_LET      = 6'd4;
  localparam logic [5:0] K_FOR      = 6'd5;
  localparam logic [5:0] K_WHILE    = 6'd6;
  localparam logic [5:0] K_MUT      = 6'd7;
  localparam logic [5:0] K_MOD      = 6'd8;
  localparam logic [5:0] K_USE      = 6'd9;
  localparam logic [5:0] K_TYPE     = 6'd10;
  localparam logic [5:0] K_MATCH    = 6'd11;
  localparam logic [5:0] K_IN       = 6'd12;
  localparam logic [5:0] K_AND      = 6'd13;
  localparam logic [5:0] K_OR       = 6'd14;
  localparam logic [5:0] K_NAME     = 6'd15;
  localparam logic [5:0] K_INT      = 6'd16;
  localparam logic [5:0] K_FLOAT    = 6'd17;
  localparam logic [5:0] K_STR      = 6'd18;
  localparam logic [5:0] K_COLON    = 6'd19;
  localparam logic [5:0] K_DOT      = 6'd20;
  localparam logic [5:0] K_LPAR     = 6'd21;
  localparam logic [5:0] K_RPAR     = 6'd22;
  localparam logic [5:0] K_LBRAC    = 6'd23;
  localparam logic [5:0] K_RBRAC    = 6'd24;
  localparam logic [5:0] K_SEMI     = 6'd25;
  localparam logic [5:0] K_PIPE     = 6'd26;
  localparam logic [5:0] K_BAR      = 6'd27;
  localparam logic [5:0] K_ARROW    = 6'd28;
  localparam logic [5:0] K_DEQ      = 6'd29;
  localparam logic [5:0] K_NOTEQ    = 6'd30;
  localparam logic [5:0] K_LESSEQ   = 6'd31;
  localparam logic [5:0] K_LESS     = 6'd32;
  localparam logic [5:0] K_GREATEQ  = 6'd33;
  localparam logic [5:0] K_GREAT    = 6'd34;
  localparam logic [5:0] K_EQ       = 6'd35;
  localparam logic [5:0] K_PLUSEQ   = 6'd36;
  localparam logic [5:0] K_PLUS     = 6'd37;
  localparam logic [5:0] K_MINUSEQ  = 6'd38;
  localparam logic [5:0] K_MINUS    = 6'd39;
  localparam logic [5:0] K_DSTAREQ  = 6'd40;
  localparam logic [5:0] K_DSTAR    = 6'd41;
  localparam logic [5:0] K_STAREQ   = 6'd42;
  localparam logic [5:0] K_STAR     = 6'd43;
  localparam logic [5:0] K_DSLASHEQ = 6'd44;
  localparam logic [5:0] K_DSLASH   = 6'd45;
  localparam logic [5:0] K_SLASHEQ  = 6'd46;
  localparam logic [5:0] K_SLASH    = 6'd47;
  localparam logic [5:0] K_EOF      = 6'd48;
  localparam logic [5:0] K_ERR      = 6'd49;

  // error codes
  localparam logic [1:0] E_UNEXPECTED = 2'd0;
  localparam logic [1:0] E_NL_IN_STR  = 2'd1;
  localparam logic [1:0] E_OPEN_STR   = 2'd2;

  // one result token
  typedef struct packed {
    logic [5:0]  kind;
    logic [15:0] line;
    logic [15:0] col;
    logic [31:0] off;
    logic [15:0] len;
    logic        bv;
    logic [1:0]  ec;
    logic [7:0]  bad;
    logic        last;
  } tok_t;

endpackage

>>> hdl/iatl_in_if.sv
`timescale 1ns / 1ps

interface iatl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] source_byte;
  logic       end_of_input;

  modport source (output valid, output source_byte, output end_of_input, input ready);
  modport sink (input valid, input source_byte, input end_of_input, output ready);
endinterface

>>> hdl/iatl_out_if.sv
`timescale 1ns / 1ps

interface iatl_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  token_kind;
  logic [15:0] start_line;
  logic [15:0] start_column;
  logic [31:0] value_offset;
  logic [15:0] value_length;
  logic        bool_value;
  logic [1:0]  error_code;
  logic [7:0]  bad_char;
  logic        last_of_run;

  modport source (output valid, output token_kind, output start_line, output start_column,
                  output value_offset, output value_length, output bool_value,
                  output error_code, output bad_char, output last_of_run, input ready);
  modport sink (input valid, input token_kind, input start_line, input start_column,
                input value_offset, input value_length, input bool_value,
                input error_code, input bad_char, input last_of_run, output ready);
endinterface

>>> hdl/indent_aware_token_lexer.sv
`timescale 1ns / 1ps

// channel  | dir | transfer when        | payload
// in_chan  | in  | valid & ready        | source_byte, end_of_input
// out_chan | out | valid & ready        | token fields, last_of_run
// cfg      | in  | cfg_wr_en            | tab_width
//
// one byte is taken per cycle while in_chan.ready is high; its up to two tokens go to a four-entry output queue
// in_chan.ready drops when fewer than two queue entries are free
// end of input emits one dedent per open level then EOF, one per cycle while the queue has room
// no input is taken while that dedent run drains; later items are taken and dropped
// reset is synchronous; output stalls only back up through the queue

module indent_aware_token_lexer import iatl_pkg::*; #(
  parameter int MAX_DEPTH      = 32,
  parameter int POSITION_WIDTH = 16,
  parameter int KEYWORD_BYTES  = 5
) (
  input  logic       clk,
  input  logic       rst_n,
  iatl_in_if.sink    in_chan,
  iatl_out_if.source out_chan,
  input  logic       cfg_wr_en,
  input  logic [4:0] cfg_wr_data
);

  localparam int DW = $clog2(MAX_DEPTH + 1);
  localparam int PW = POSITION_WIDTH;
  localparam int KW = 8 * KEYWORD_BYTES;
  localparam logic [PW-1:0] POS_MAX = {PW{1'b1}};
  localparam logic [DW-1:0] DEPTH_MAX = DW'(MAX_DEPTH);

  // scan modes
  localparam logic [3:0] M_IDLE    = 4'd0;
  localparam logic [3:0] M_NAME    = 4'd1;
  localparam logic [3:0] M_NUMBER  = 4'd2;
  localparam logic [3:0] M_DOT     = 4'd3;
  localparam logic [3:0] M_STRING  = 4'd4;
  localparam logic [3:0] M_COMMENT = 4'd5;
  localparam logic [3:0] M_NL      = 4'd6;
  localparam logic [3:0] M_NLWS    = 4'd7;
  localparam logic [3:0] M_OP1     = 4'd8;
  localparam logic [3:0] M_OP2     = 4'd9;

  localparam logic [5:0] K_NONE = K_INDENT;

  function automatic logic is_alpha(input logic [7:0] ch);
    return (ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z") || ch == "_";
  endfunction

  function automatic logic is_digit(input logic [7:0] ch);
    return ch >= "0" && ch <= "9";
  endfunction

  function automatic logic is_blank(input logic [7:0] ch);
    return ch == " " || ch == 8'h09;
  endfunction

  // keyword match on the first five bytes, low byte first; returns {bool, kind}
  function automatic logic [6:0] kw_lookup(input logic [39:0] w, input logic [15:0] n);
    logic [6:0] r;
    r = {1'b0, K_NAME};
    case (n)
      16'd2: begin
        if (w == 40'h00_00_00_6e_69) r = {1'b0, K_IN};
        else if (w == 40'h00_00_00_72_6f) r = {1'b0, K_OR};
      end
      16'd3: begin
        if (w == 40'h00_00_74_65_6c) r = {1'b0, K_LET};
        else if (w == 40'h00_00_72_6f_66) r = {1'b0, K_FOR};
        else if (w == 40'h00_00_74_75_6d) r = {1'b0, K_MUT};
        else if (w == 40'h00_00_64_6f_6d) r = {1'b0, K_MOD};
        else if (w == 40'h00_00_65_73_75) r = {1'b0, K_USE};
        else if (w == 40'h00_00_64_6e_61) r = {1'b0, K_AND};
      end
      16'd4: begin
        if (w == 40'h00_65_75_72_74) r = {1'b1, K_BOOL};
        else if (w == 40'h00_65_70_79_74) r = {1'b0, K_TYPE};
      end
      16'd5: begin
        if (w == 40'h65_73_6c_61_66) r = {1'b0, K_BOOL};
        else if (w == 40'h65_6c_69_68_77) r = {1'b0, K_WHILE};
        else if (w == 40'h68_63_74_61_6d) r = {1'b0, K_MATCH};
      end
      default: r = {1'b0, K_NAME};
    endcase
    return r;
  endfunction

  function automatic logic [5:0] single_kind(input logic [7:0] p);
    case (p)
      "|":     return K_BAR;
      "=":     return K_EQ;
      "<":     return K_LESS;
      ">":     return K_GREAT;
      "+":     return K_PLUS;
      "-":     return K_MINUS;
      "*":     return K_STAR;
      default: return K_SLASH;
    endcase
  endfunction

  function automatic logic [5:0] pair_kind(input logic [7:0] p, input logic [7:0] ch);
    logic [5:0] k;
    k = K_NONE;
    if (ch == ">") begin
      if (p == "|") k = K_PIPE;
      else if (p == "=") k = K_ARROW;
    end else if (ch == "=") begin
      case (p)
        "=":     k = K_DEQ;
        "!":     k = K_NOTEQ;
        "<":     k = K_LESSEQ;
        ">":     k = K_GREATEQ;
        "+":     k = K_PLUSEQ;
        "-":     k = K_MINUSEQ;
        "*":     k = K_STAREQ;
        "/":     k = K_SLASHEQ;
        default: k = K_NONE;
      endcase
    end
    return k;
  endfunction

  function automatic tok_t mk_tok(input logic [5:0] kind, input logic [PW-1:0] line,
                                  input logic [PW-1:0] col, input logic [31:0] off,
                                  input logic [15:0] len, input logic bv,
                                  input logic [1:0] ec, input logic [7:0] bad);
    tok_t t;
    t.kind = kind;
    t.line = 16'(line);
    t.col  = 16'(col);
    t.off  = off;
    t.len  = len;
    t.bv   = bv;
    t.ec   = ec;
    t.bad  = bad;
    t.last = 1'b0;
    return t;
  endfunction

  // lexer state
  logic [3:0]    mode_r, mode_nxt;
  logic [PW-1:0] cur_line_r, cur_line_nxt, cur_col_r, cur_col_nxt;
  logic [PW-1:0] tok_line_r, tok_line_nxt, tok_col_r, tok_col_nxt;
  logic [31:0]   byte_idx_r, byte_idx_nxt, val_start_r, val_start_nxt;
  logic [15:0]   val_cnt_r, val_cnt_nxt;
  logic [15:0]   prev_ind_r, prev_ind_nxt, run_ind_r, run_ind_nxt;
  logic [DW-1:0] depth_r, depth_nxt;
  logic [KW-1:0] kw_r, kw_nxt;
  logic [7:0]    pend_op_r, pend_op_nxt;
  logic          dq_r, dq_nxt, dot_seen_r, dot_seen_nxt, stopped_r, stopped_nxt;
  logic [4:0]    tab_r;
  logic          drain_r, drain_nxt;
  logic [DW-1:0] drain_cnt_r, drain_cnt_nxt;

  // per-byte work
  logic          in_fire, eoi;
  logic [7:0]    ch;
  logic [1:0]    n_e;
  tok_t          e_tok [2];
  logic          do_close, close_ok, go_fresh, do_adv;
  logic [5:0]    pk;
  logic [6:0]    kw_hit;
  logic [16:0]   ind_sum;
  logic [15:0]   cnt_inc;

  // queue side
  logic [1:0]    push_num;
  tok_t          push_tok0, push_tok1, drain_tok, head_tok;
  logic          room1, room2, head_valid, pop;

  assign ch       = in_chan.source_byte;
  assign eoi      = in_chan.end_of_input || (ch == 8'd0);
  assign in_fire  = in_chan.valid && in_chan.ready;
  assign in_chan.ready = room2 && !drain_r;
  assign cnt_inc  = (val_cnt_r != 16'hFFFF) ? val_cnt_r + 16'd1 : val_cnt_r;
  assign pk       = pair_kind(pend_op_r, ch);
  assign kw_hit   = kw_lookup(kw_r[39:0], val_cnt_r);
  assign ind_sum  = {1'b0, run_ind_r} + ((ch == 8'h09) ? 17'(tab_r) : 17'd1);

  // next state and emitted tokens for one accepted byte, and the end-of-input dedent run
  always_comb begin
    mode_nxt      = mode_r;
    cur_line_nxt  = cur_line_r;
    cur_col_nxt   = cur_col_r;
    tok_line_nxt  = tok_line_r;
    tok_col_nxt   = tok_col_r;
    byte_idx_nxt  = byte_idx_r;
    val_start_nxt = val_start_r;
    val_cnt_nxt   = val_cnt_r;
    prev_ind_nxt  = prev_ind_r;
    run_ind_nxt   = run_ind_r;
    depth_nxt     = depth_r;
    kw_nxt        = kw_r;
    pend_op_nxt   = pend_op_r;
    dq_nxt        = dq_r;
    dot_seen_nxt  = dot_seen_r;
    stopped_nxt   = stopped_r;
    drain_nxt     = drain_r;
    drain_cnt_nxt = drain_cnt_r;
    n_e           = 2'd0;
    e_tok[0]      = '0;
    e_tok[1]      = '0;
    do_close      = 1'b0;
    close_ok      = 1'b1;
    go_fresh      = 1'b0;
    do_adv        = 1'b0;

    if (in_fire && !stopped_r) begin
      if (eoi) begin
        if (mode_r == M_STRING) begin
          e_tok[0]    = mk_tok(K_ERR, tok_line_r, tok_col_r, 32'd0, 16'd0, 1'b0,
                               E_OPEN_STR, 8'd0);
          n_e         = 2'd1;
          stopped_nxt = 1'b1;
          mode_nxt    = M_IDLE;
        end else begin
          do_close = 1'b1;
        end
      end else begin
        case (mode_r)
          M_IDLE: go_fresh = 1'b1;
          M_NAME: begin
            if (is_alpha(ch) || is_digit(ch)) begin
              for (int i = 0; i < KEYWORD_BYTES; i++) begin
                if (val_cnt_r == 16'(i)) kw_nxt[8*i +: 8] = ch;
              end
              val_cnt_nxt = cnt_inc;
              do_adv      = 1'b1;
            end else begin
              do_close = 1'b1;
            end
          end
          M_NUMBER: begin
            if (is_digit(ch)) begin
              val_cnt_nxt = cnt_inc;
              do_adv      = 1'b1;
            end else if (ch == "." && !dot_seen_r) begin
              dot_seen_nxt = 1'b1;
              val_cnt_nxt  = cnt_inc;
              do_adv       = 1'b1;
            end else begin
              do_close = 1'b1;
            end
          end
          M_DOT: begin
            if (is_digit(ch)) begin
              mode_nxt     = M_NUMBER;
              dot_seen_nxt = 1'b1;
              val_cnt_nxt  = 16'd2;
              do_adv       = 1'b1;
            end else begin
              do_close = 1'b1;
            end
          end
          M_STRING: begin
            if (ch == (dq_r ? 8'h22 : 8'h27)) begin
              e_tok[0] = mk_tok(K_STR, tok_line_r, tok_col_r, val_start_r, val_cnt_r,
                                1'b0, E_UNEXPECTED, 8'd0);
              n_e      = 2'd1;
              mode_nxt = M_IDLE;
              do_adv   = 1'b1;
            end else if (ch == 8'h0a) begin
              e_tok[0]    = mk_tok(K_ERR, tok_line_r, tok_col_r, 32'd0, 16'd0, 1'b0,
                                   E_NL_IN_STR, 8'd0);
              n_e         = 2'd1;
              stopped_nxt = 1'b1;
              mode_nxt    = M_IDLE;
            end else begin
              val_cnt_nxt = cnt_inc;
              do_adv      = 1'b1;
            end
          end
          M_COMMENT: begin
            do_adv = 1'b1;
            if (ch == 8'h0a) mode_nxt = M_IDLE;
          end
          M_NL, M_NLWS: begin
            if (mode_r == M_NL && ch == 8'h0a) begin
              do_adv = 1'b1;
            end else if (is_blank(ch)) begin
              run_ind_nxt = ind_sum[16] ? 16'hFFFF : ind_sum[15:0];
              mode_nxt    = M_NLWS;
              do_adv      = 1'b1;
            end else begin
              do_close = 1'b1;
            end
          end
          M_OP1: begin
            if (pk != K_NONE) begin
              e_tok[0] = mk_tok(pk, tok_line_r, tok_col_r, 32'd0, 16'd0, 1'b0,
                                E_UNEXPECTED, 8'd0);
              n_e      = 2'd1;
              mode_nxt = M_IDLE;
              do_adv   = 1'b1;
            end else if ((pend_op_r == "*" || pend_op_r == "/") && ch == pend_op_r) begin
              mode_nxt = M_OP2;
              do_adv   = 1'b1;
            end else begin
              do_close = 1'b1;
            end
          end
          M_OP2: begin
            if (ch == "=") begin
              e_tok[0] = mk_tok((pend_op_r == "*") ? K_DSTAREQ : K_DSLASHEQ, tok_line_r,
                                tok_col_r, 32'd0, 16'd0, 1'b0, E_UNEXPECTED, 8'd0);
              n_e      = 2'd1;
              mode_nxt = M_IDLE;
              do_adv   = 1'b1;
            end else begin
              do_close = 1'b1;
            end
          end
          default: go_fresh = 1'b1;
        endcase
      end

      // close what the current mode holds
      if (do_close) begin
        mode_nxt = M_IDLE;
        case (mode_r)
          M_NAME: begin
            e_tok[0] = mk_tok(kw_hit[5:0], tok_line_r, tok_col_r, val_start_r, val_cnt_r,
                              kw_hit[6], E_UNEXPECTED, 8'd0);
            n_e      = 2'd1;
          end
          M_NUMBER: begin
            e_tok[0] = mk_tok(dot_seen_r ? K_FLOAT : K_INT, tok_line_r, tok_col_r,
                              val_start_r, val_cnt_r, 1'b0, E_UNEXPECTED, 8'd0);
            n_e      = 2'd1;
          end
          M_DOT: begin
            e_tok[0] = mk_tok(K_DOT, tok_line_r, tok_col_r, 32'd0, 16'd0, 1'b0,
                              E_UNEXPECTED, 8'd0);
            n_e      = 2'd1;
          end
          M_NL, M_NLWS: begin
            if (run_ind_r > prev_ind_r) begin
              if (depth_r < DEPTH_MAX) depth_nxt = depth_r + DW'(1);
              e_tok[0] = mk_tok(K_INDENT, tok_line_r, tok_col_r, 32'd0, 16'd0, 1'b0,
                                E_UNEXPECTED, 8'd0);
            end else if (run_ind_r < prev_ind_r) begin
              if (depth_r != '0) depth_nxt = depth_r - DW'(1);
              e_tok[0] = mk_tok(K_DEDENT, tok_line_r, tok_col_r, 32'd0, 16'd0, 1'b0,
                                E_UNEXPECTED, 8'd0);
            end else begin
              e_tok[0] = mk_tok(K_EOL, tok_line_r, tok_col_r, 32'd0, 16'd0, 1'b0,
                                E_UNEXPECTED, 8'd0);
            end
            prev_ind_nxt = run_ind_r;
            n_e          = 2'd1;
          end
          M_OP1: begin
            if (pend_op_r == "!") begin
              e_tok[0]    = mk_tok(K_ERR, tok_line_r, tok_col_r, 32'd0, 16'd0, 1'b0,
                                   E_UNEXPECTED, "!");
              stopped_nxt = 1'b1;
              close_ok    = 1'b0;
            end else begin
              e_tok[0] = mk_tok(single_kind(pend_op_r), tok_line_r, tok_col_r, 32'd0,
                                16'd0, 1'b0, E_UNEXPECTED, 8'd0);
            end
            n_e = 2'd1;
          end
          M_OP2: begin
            e_tok[0] = mk_tok((pend_op_r == "*") ? K_DSTAR : K_DSLASH, tok_line_r,
                              tok_col_r, 32'd0, 16'd0, 1'b0, E_UNEXPECTED, 8'd0);
            n_e      = 2'd1;
          end
          default: n_e = 2'd0;
        endcase
        if (close_ok) begin
          if (eoi) begin
            tok_line_nxt  = cur_line_r;
            tok_col_nxt   = cur_col_r;
            drain_cnt_nxt = depth_nxt;
            drain_nxt     = 1'b1;
            stopped_nxt   = 1'b1;
          end else begin
            go_fresh = 1'b1;
          end
        end
      end

      // start on a byte with nothing pending
      if (go_fresh) begin
        mode_nxt = M_IDLE;
        if (is_blank(ch)) begin
          do_adv = 1'b1;
        end else if (ch == "#") begin
          mode_nxt = M_COMMENT;
          do_adv   = 1'b1;
        end else begin
          tok_line_nxt  = cur_line_r;
          tok_col_nxt   = cur_col_r;
          val_start_nxt = byte_idx_r;
          val_cnt_nxt   = 16'd0;
          kw_nxt        = '0;
          dot_seen_nxt  = 1'b0;
          do_adv        = 1'b1;
          if (ch == 8'h0a) begin
            run_ind_nxt = 16'd0;
            mode_nxt    = M_NL;
          end else if (is_alpha(ch)) begin
            kw_nxt[7:0] = ch;
            val_cnt_nxt = 16'd1;
            mode_nxt    = M_NAME;
          end else if (is_digit(ch)) begin
            val_cnt_nxt = 16'd1;
            mode_nxt    = M_NUMBER;
          end else if (ch == ".") begin
            mode_nxt = M_DOT;
          end else if (ch == 8'h22 || ch == 8'h27) begin
            dq_nxt        = (ch == 8'h22);
            val_start_nxt = byte_idx_r + 32'd1;
            mode_nxt      = M_STRING;
          end else if (ch == ":" || ch == "(" || ch == ")" || ch == "[" || ch == "]" ||
                       ch == ";") begin
            case (ch)
              ":":     e_tok[n_e[0]] = mk_tok(K_COLON, cur_line_r, cur_col_r, 32'd0,
                                              16'd0, 1'b0, E_UNEXPECTED, 8'd0);
              "(":     e_tok[n_e[0]] = mk_tok(K_LPAR, cur_line_r, cur_col_r, 32'd0,
                                              16'd0, 1'b0, E_UNEXPECTED, 8'd0);
              ")":     e_tok[n_e[0]] = mk_tok(K_RPAR, cur_line_r, cur_col_r, 32'd0,
                                              16'd0, 1'b0, E_UNEXPECTED, 8'd0);
              "[":     e_tok[n_e[0]] = mk_tok(K_LBRAC, cur_line_r, cur_col_r, 32'd0,
                                              16'd0, 1'b0, E_UNEXPECTED, 8'd0);
              "]":     e_tok[n_e[0]] = mk_tok(K_RBRAC, cur_line_r, cur_col_r, 32'd0,
                                              16'd0, 1'b0, E_UNEXPECTED, 8'd0);
              default: e_tok[n_e[0]] = mk_tok(K_SEMI, cur_line_r, cur_col_r, 32'd0,
                                              16'd0, 1'b0, E_UNEXPECTED, 8'd0);
            endcase
            n_e = n_e + 2'd1;
          end else if (ch == "|" || ch == "=" || ch == "!" || ch == "<" || ch == ">" ||
                       ch == "+" || ch == "-" || ch == "*" || ch == "/") begin
            pend_op_nxt = ch;
            mode_nxt    = M_OP1;
          end else begin
            e_tok[n_e[0]] = mk_tok(K_ERR, cur_line_r, cur_col_r, 32'd0, 16'd0, 1'b0,
                                   E_UNEXPECTED, ch);
            n_e           = n_e + 2'd1;
            stopped_nxt   = 1'b1;
            do_adv        = 1'b0;
          end
        end
      end

      // position counters
      if (do_adv) begin
        byte_idx_nxt = byte_idx_r + 32'd1;
        if (ch == 8'h0a) begin
          cur_line_nxt = (cur_line_r != POS_MAX) ? cur_line_r + PW'(1) : cur_line_r;
          cur_col_nxt  = PW'(1);
        end else begin
          cur_col_nxt = (cur_col_r != POS_MAX) ? cur_col_r + PW'(1) : cur_col_r;
        end
      end

      // mark the final token of this byte
      if (!drain_nxt) begin
        if (n_e == 2'd2) e_tok[1].last = 1'b1;
        else if (n_e == 2'd1) e_tok[0].last = 1'b1;
      end
    end

    // end-of-input dedent run
    drain_tok = mk_tok((drain_cnt_r != '0) ? K_DEDENT : K_EOF, tok_line_r, tok_col_r,
                       32'd0, 16'd0, 1'b0, E_UNEXPECTED, 8'd0);
    drain_tok.last = (drain_cnt_r == '0);
    if (drain_r && room1) begin
      if (drain_cnt_r != '0) drain_cnt_nxt = drain_cnt_r - DW'(1);
      else drain_nxt = 1'b0;
    end
  end

  // queue write side
  always_comb begin
    if (drain_r) begin
      push_num  = room1 ? 2'd1 : 2'd0;
      push_tok0 = drain_tok;
      push_tok1 = drain_tok;
    end else begin
      push_num  = n_e;
      push_tok0 = e_tok[0];
      push_tok1 = e_tok[1];
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= M_IDLE;
      cur_line_r  <= PW'(1);
      cur_col_r   <= PW'(1);
      tok_line_r  <= PW'(1);
      tok_col_r   <= PW'(1);
      byte_idx_r  <= 32'd0;
      val_start_r <= 32'd0;
      val_cnt_r   <= 16'd0;
      prev_ind_r  <= 16'd0;
      run_ind_r   <= 16'd0;
      depth_r     <= '0;
      kw_r        <= '0;
      pend_op_r   <= 8'd0;
      dq_r        <= 1'b0;
      dot_seen_r  <= 1'b0;
      stopped_r   <= 1'b0;
      drain_r     <= 1'b0;
      drain_cnt_r <= '0;
    end else begin
      mode_r      <= mode_nxt;
      cur_line_r  <= cur_line_nxt;
      cur_col_r   <= cur_col_nxt;
      tok_line_r  <= tok_line_nxt;
      tok_col_r   <= tok_col_nxt;
      byte_idx_r  <= byte_idx_nxt;
      val_start_r <= val_start_nxt;
      val_cnt_r   <= val_cnt_nxt;
      prev_ind_r  <= prev_ind_nxt;
      run_ind_r   <= run_ind_nxt;
      depth_r     <= depth_nxt;
      kw_r        <= kw_nxt;
      pend_op_r   <= pend_op_nxt;
      dq_r        <= dq_nxt;
      dot_seen_r  <= dot_seen_nxt;
      stopped_r   <= stopped_nxt;
      drain_r     <= drain_nxt;
      drain_cnt_r <= drain_cnt_nxt;
    end
  end

  // tab width register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tab_r <= 5'd8;
    end else if (cfg_wr_en) begin
      tab_r <= cfg_wr_data;
    end
  end

  iatl_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_num   (push_num),
    .push_tok0  (push_tok0),
    .push_tok1  (push_tok1),
    .room1      (room1),
    .room2      (room2),
    .head_valid (head_valid),
    .head_tok   (head_tok),
    .pop        (pop)
  );

  // result channel
  assign pop                   = head_valid && out_chan.ready;
  assign out_chan.valid        = head_valid;
  assign out_chan.token_kind   = head_tok.kind;
  assign out_chan.start_line   = head_tok.line;
  assign out_chan.start_column = head_tok.col;
  assign out_chan.value_offset = head_tok.off;
  assign out_chan.value_length = head_tok.len;
  assign out_chan.bool_value   = head_tok.bv;
  assign out_chan.error_code   = head_tok.ec;
  assign out_chan.bad_char     = head_tok.bad;
  assign out_chan.last_of_run  = head_tok.last;

endmodule

>>> hdl/iatl_fifo.sv
`timescale 1ns / 1ps

module iatl_fifo import iatl_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [1:0] push_num,
  input  tok_t       push_tok0,
  input  tok_t       push_tok1,
  output logic       room1,
  output logic       room2,
  output logic       head_valid,
  output tok_t       head_tok,
  input  logic       pop
);

  tok_t       mem_r [4];
  logic [1:0] wr_ptr_r, rd_ptr_r;
  logic [2:0] count_r;
  logic [1:0] wr_ptr1;

  assign wr_ptr1    = wr_ptr_r + 2'd1;
  assign room1      = (count_r <= 3'd3);
  assign room2      = (count_r <= 3'd2);
  assign head_valid = (count_r != 3'd0);
  assign head_tok   = mem_r[rd_ptr_r];

  // token storage
  always_ff @(posedge clk) begin
    if (push_num != 2'd0) begin
      mem_r[wr_ptr_r] <= push_tok0;
    end
    if (push_num == 2'd2) begin
      mem_r[wr_ptr1] <= push_tok1;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 2'd0;
      rd_ptr_r <= 2'd0;
      count_r  <= 3'd0;
    end else begin
      wr_ptr_r <= wr_ptr_r + push_num;
      rd_ptr_r <= rd_ptr_r + {1'b0, pop};
      count_r  <= count_r + {1'b0, push_num} - {2'b0, pop};
    end
  end

endmodule

>>> hdl/iatl_checker.sv
`timescale 1ns / 1ps
`include "indent_aware_token_lexer_assert.svh"

module iatl_checker import iatl_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [5:0] out_kind,
  input logic [1:0] out_ec,
  input logic       out_last
);

  // a stalled token holds
  `IATL_ASSERT_NEXT(a_stall_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_kind), "stalled token changed")

  // nothing follows the end-of-file token
  `IATL_ASSERT_NEXT(a_eof_final, clk, rst_n, out_valid && out_ready && out_kind == K_EOF, !out_valid, "token after EOF")

  // an error ends its run
  `IATL_ASSERT_NOW(a_err_last, clk, rst_n, out_valid && out_kind == K_ERR, out_last, "error not last of run")

  // error code only on error tokens
  `IATL_ASSERT_NOW(a_ec_zero, clk, rst_n, out_valid && out_kind != K_ERR, out_ec == E_UNEXPECTED, "error code on plain token")

endmodule

bind indent_aware_token_lexer iatl_checker u_iatl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_kind  (out_chan.token_kind),
  .out_ec    (out_chan.error_code),
  .out_last  (out_chan.last_of_run)
);
